### sv/assert_macros.svh
// Assertion helpers used by vm_integer_alu32_core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, pre, post)
`define ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

### sv/ialu_pkg.sv
package ialu_pkg;
   localparam int unsigned Width = 32;

   typedef enum logic [3:0] {
      OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3,
      OP_MOD = 4'd4, OP_NEG = 4'd5, OP_AND = 4'd6, OP_OR = 4'd7,
      OP_XOR = 4'd8, OP_NOT = 4'd9, OP_SHL = 4'd10, OP_SAR = 4'd11,
      OP_SHR = 4'd12
   } op_type;

   // word travelling down the divider chain
   typedef struct packed {
      logic             valid;
      logic [3:0]       op;
      logic [Width-1:0] fast;     // result of the ops computed in the decode cell
      logic [Width-1:0] quo;      // dividend shifting out, quotient in
      logic [Width-1:0] rem;      // partial remainder
      logic [Width-1:0] dvs;      // divisor magnitude
      logic             neg_q;
      logic             neg_r;
      logic             dz;
   } word_type;
endpackage

### sv/ialu_front.sv
// Decode cell: non-divide ops, multiplier low product, divider setup
module ialu_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [3:0]                   op,
   input  logic [ialu_pkg::Width-1:0]   a,
   input  logic [ialu_pkg::Width-1:0]   b,
   output ialu_pkg::word_type           word_out
);
   ialu_pkg::word_type word_ff, word_in;
   logic [ialu_pkg::Width-1:0] mag_a, mag_b, fast;
   logic                       big;
   logic [4:0]                 sh, sar_sh;

   always_comb begin
      mag_a  = a[ialu_pkg::Width-1] ? (~a + 1'b1) : a;
      mag_b  = b[ialu_pkg::Width-1] ? (~b + 1'b1) : b;
      big    = |b[ialu_pkg::Width-1:5];
      sh     = b[4:0];
      sar_sh = big ? 5'd31 : sh;
      case (op)
         ialu_pkg::OP_ADD: fast = a + b;
         ialu_pkg::OP_SUB: fast = a - b;
         ialu_pkg::OP_MUL: fast = a * b;
         ialu_pkg::OP_NEG: fast = ~a + 1'b1;
         ialu_pkg::OP_AND: fast = a & b;
         ialu_pkg::OP_OR:  fast = a | b;
         ialu_pkg::OP_XOR: fast = a ^ b;
         ialu_pkg::OP_NOT: fast = ~a;
         ialu_pkg::OP_SHL: fast = big ? '0 : (a << sh);
         ialu_pkg::OP_SAR: fast = $signed(a) >>> sar_sh;
         ialu_pkg::OP_SHR: fast = big ? '0 : (a >> sh);
         default:          fast = '0;
      endcase
      word_in.valid = start;
      word_in.op    = op;
      word_in.fast  = fast;
      word_in.quo   = mag_a;
      word_in.rem   = '0;
      word_in.dvs   = mag_b;
      word_in.neg_q = a[ialu_pkg::Width-1] ^ b[ialu_pkg::Width-1];
      word_in.neg_r = a[ialu_pkg::Width-1];
      word_in.dz    = (b == '0) && (op == ialu_pkg::OP_DIV || op == ialu_pkg::OP_MOD);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff.valid <= 1'b0;
      end else begin
         word_ff.valid <= word_in.valid;
      end
      word_ff.op    <= word_in.op;
      word_ff.fast  <= word_in.fast;
      word_ff.quo   <= word_in.quo;
      word_ff.rem   <= word_in.rem;
      word_ff.dvs   <= word_in.dvs;
      word_ff.neg_q <= word_in.neg_q;
      word_ff.neg_r <= word_in.neg_r;
      word_ff.dz    <= word_in.dz;
   end

   assign word_out = word_ff;
endmodule

### sv/ialu_div_cell.sv
// Restoring divide cell: one quotient bit per cycle
module ialu_div_cell (
   input  logic               clock,
   input  logic               reset,
   input  ialu_pkg::word_type word_in_w,
   output ialu_pkg::word_type word_out
);
   ialu_pkg::word_type word_ff, word_in;
   logic [ialu_pkg::Width:0]   trial;
   logic [ialu_pkg::Width:0]   diff;

   always_comb begin
      word_in = word_in_w;
      trial   = {word_in_w.rem, word_in_w.quo[ialu_pkg::Width-1]};
      diff    = trial - {1'b0, word_in_w.dvs};
      if (!diff[ialu_pkg::Width]) begin
         word_in.rem = diff[ialu_pkg::Width-1:0];
         word_in.quo = {word_in_w.quo[ialu_pkg::Width-2:0], 1'b1};
      end else begin
         word_in.rem = trial[ialu_pkg::Width-1:0];
         word_in.quo = {word_in_w.quo[ialu_pkg::Width-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff.valid <= 1'b0;
      end else begin
         word_ff.valid <= word_in.valid;
      end
      word_ff.op    <= word_in.op;
      word_ff.fast  <= word_in.fast;
      word_ff.quo   <= word_in.quo;
      word_ff.rem   <= word_in.rem;
      word_ff.dvs   <= word_in.dvs;
      word_ff.neg_q <= word_in.neg_q;
      word_ff.neg_r <= word_in.neg_r;
      word_ff.dz    <= word_in.dz;
   end

   assign word_out = word_ff;
endmodule

### sv/vm_integer_alu32_core.sv
// channel   ports                                   direction
// request   start, busy, req_op/operand_a/operand_b in (start & !busy)
// response  rsp_valid, rsp_result, rsp_div_zero    out, one-cycle strobe
//
// Every word passes from start to rsp_valid through one decode cell,
// 32 divide cells (one quotient bit each), one output register.
// A new word is taken every cycle; busy is only high during reset.
// Reset is synchronous and clears the valid bits down the chain.
// The receiver cannot stall; every result is shown for one cycle.
`include "assert_macros.svh"
module vm_integer_alu32_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [3:0]  req_op,
   input  logic [31:0] req_operand_a,
   input  logic [31:0] req_operand_b,
   output logic        rsp_valid,
   output logic [31:0] rsp_result,
   output logic        rsp_div_zero
);
   ialu_pkg::word_type chain [0:ialu_pkg::Width];
   logic        valid_ff, valid_in;
   logic [31:0] result_ff, result_in;
   logic        dz_ff, dz_in;
   ialu_pkg::word_type last;
   logic        last_divmod;

   assign busy = reset;

   ialu_front u_front (
      .clock(clock), .reset(reset), .start(start & ~busy), .op(req_op),
      .a(req_operand_a), .b(req_operand_b), .word_out(chain[0])
   );

   // row of divide cells
   for (genvar i = 0; i < ialu_pkg::Width; i++) begin : g_cell
      ialu_div_cell u_cell (
         .clock(clock), .reset(reset), .word_in_w(chain[i]), .word_out(chain[i+1])
      );
   end

   // result select
   always_comb begin
      last        = chain[ialu_pkg::Width];
      last_divmod = (last.op == ialu_pkg::OP_DIV) || (last.op == ialu_pkg::OP_MOD);
      valid_in    = last.valid;
      dz_in       = last.dz;
      if (last.dz) begin
         result_in = '0;
      end else if (last.op == ialu_pkg::OP_DIV) begin
         result_in = last.neg_q ? (~last.quo + 1'b1) : last.quo;
      end else if (last.op == ialu_pkg::OP_MOD) begin
         result_in = last.neg_r ? (~last.rem + 1'b1) : last.rem;
      end else begin
         result_in = last.fast;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      result_ff <= result_in;
      dz_ff     <= dz_in;
   end

   assign rsp_valid    = valid_ff;
   assign rsp_result   = result_ff;
   assign rsp_div_zero = dz_ff;

   `ASSERT_IMPLIES(a_dz_zero, clock, reset, rsp_valid && rsp_div_zero, rsp_result == 32'd0)
   `ASSERT_NEXT(a_last_valid, clock, reset, last.valid, rsp_valid)
   `ASSERT_IMPLIES(a_dz_op, clock, reset, last.valid && last.dz, last_divmod)
endmodule
